// ===== hw/rtl/iti_pkg.sv =====
`default_nettype none
package iti_pkg;

   localparam int unsigned DigitLimit = 10;
   localparam int unsigned CountSat   = 11;
   localparam int unsigned CountW     = 4;

   localparam logic [7:0] AsciiZero = 8'h30;
   localparam logic [7:0] AsciiNine = 8'h39;

   // Values handed from the accumulator to the output stage at the end of an identifier.
   typedef struct packed {
      logic [31:0] hash;
      logic [31:0] value;
      logic        clean;
   } fin_type;

   function automatic logic [31:0] hash_absorb(input logic [31:0] h_in, input logic [7:0] b);
      logic [31:0] h;
      h = h_in + {24'd0, b};
      h = h + (h << 10);
      h = h ^ (h >> 6);
      return h;
   endfunction

   function automatic logic [31:0] hash_finish(input logic [31:0] h_in);
      logic [31:0] h;
      h = h_in + (h_in << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return h;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/iti_accum.sv =====
`default_nettype none
module iti_accum (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            take,
   input  wire logic [7:0]      byte_in,
   input  wire logic            byte_present,
   input  wire logic            is_last,
   output iti_pkg::fin_type     fin
);
   import iti_pkg::*;

   logic [31:0]       hash_ff,  hash_in;
   logic [31:0]       value_ff, value_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              zero_ff,  zero_in;
   logic              nonum_ff, nonum_in;

   logic [35:0]       next_value;
   logic              is_digit;

   always_comb begin
      hash_in  = hash_ff;
      value_in = value_ff;
      count_in = count_ff;
      zero_in  = zero_ff;
      nonum_in = nonum_ff;

      is_digit   = (byte_in >= AsciiZero) && (byte_in <= AsciiNine);
      // Times ten as two shifted copies; anything above bit 31 is an overflow.
      next_value = ({4'd0, value_ff} << 3) + ({4'd0, value_ff} << 1)
                 + {28'd0, byte_in - AsciiZero};

      if (byte_present) begin
         hash_in = hash_absorb(hash_ff, byte_in);
         if ((count_ff == '0) && (byte_in == AsciiZero)) begin
            zero_in = 1'b1;
         end
         if (!is_digit) begin
            nonum_in = 1'b1;
         end else if (!nonum_ff) begin
            if (next_value[35:32] != 4'd0) begin
               nonum_in = 1'b1;
            end else begin
               value_in = next_value[31:0];
            end
         end
         if (count_ff < CountW'(CountSat)) begin
            count_in = count_ff + 1'b1;
         end
      end

      fin.hash  = hash_in;
      fin.value = value_in;
      fin.clean = !nonum_in
               && (count_in >= CountW'(1))
               && (count_in <= CountW'(DigitLimit))
               && !((count_in > CountW'(1)) && zero_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= '0;
         value_ff <= '0;
         count_ff <= '0;
         zero_ff  <= 1'b0;
         nonum_ff <= 1'b0;
      end else if (take) begin
         if (is_last) begin
            hash_ff  <= '0;
            value_ff <= '0;
            count_ff <= '0;
            zero_ff  <= 1'b0;
            nonum_ff <= 1'b0;
         end else begin
            hash_ff  <= hash_in;
            value_ff <= value_in;
            count_ff <= count_in;
            zero_ff  <= zero_in;
            nonum_ff <= nonum_in;
         end
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/identifier_to_id.sv =====
// Accepts one identifier byte per cycle, gap-free across identifiers, when not stalled.
// After its final transaction is taken, the id for an identifier is formed in order:
// the byte register feeds the hash and decimal update into the finish register, then
// hash finalization fills the output register.
// One transaction per cycle unless the output stalls; then up to two finished ids wait.
// Synchronous active-high reset clears all valid flags and the accumulated hash and value.
`default_nettype none
module identifier_to_id (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   input  wire logic        req_tuser,   // [0] byte_present
   input  wire logic        req_tlast,   // is_last
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata    // [31:0] ident
);
   import iti_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_present_ff;
   logic       in_last_ff;

   logic       fin_valid_ff;
   fin_type    fin_ff;
   fin_type    fin_in;

   logic        out_valid_ff;
   logic [31:0] out_data_ff;

   logic out_take;
   logic fin_take;
   logic in_take;

   assign out_take   = !out_valid_ff || rsp_tready;
   assign fin_take   = fin_valid_ff && out_take;
   // Only a final byte needs room in the finish stage; other bytes just update the state.
   assign in_take    = in_valid_ff && (!in_last_ff || !fin_valid_ff || out_take);
   assign req_tready = !in_valid_ff || in_take;

   iti_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .take         (in_take),
      .byte_in      (in_byte_ff),
      .byte_present (in_present_ff),
      .is_last      (in_last_ff),
      .fin          (fin_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (in_take && in_last_ff) begin
            fin_valid_ff <= 1'b1;
         end else if (fin_take) begin
            fin_valid_ff <= 1'b0;
         end
         if (out_take) begin
            out_valid_ff <= fin_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff    <= req_tdata;
         in_present_ff <= req_tuser;
         in_last_ff    <= req_tlast;
      end
      if (in_take && in_last_ff) begin
         fin_ff <= fin_in;
      end
      if (fin_take) begin
         out_data_ff <= fin_ff.clean ? fin_ff.value : hash_finish(fin_ff.hash);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire
